[rtl/wcg_pkg.sv]
`default_nettype none

package wcg_pkg;

    // field and register widths
    localparam int INDEX_W = 13;
    localparam int LEN_W   = 14;
    localparam int COEF_W  = 16;
    localparam int PHASE_W = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [LEN_W-1:0] MAX_POINTS = 14'd8192;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KIND   = 2'd1;

    typedef enum logic [1:0] {
        KIND_RECT,
        KIND_HANN,
        KIND_HAMMING,
        KIND_FLAT
    } t_kind;

    // phase divider: one quotient bit per step, DIV_STEP steps per stage
    localparam int DIV_BITS   = INDEX_W + PHASE_W;
    localparam int DIV_STEP   = 3;
    localparam int DIV_STAGES = DIV_BITS / DIV_STEP;

    // Q30 fixed point
    localparam logic [30:0] ONE_Q30 = 31'd1073741824;

    // 2*pi in Q32 split as C_HI * 2^32 + C_LO
    localparam logic [30:0] C_LO = 31'd1216271633;
    localparam logic [2:0]  C_HI = 3'd6;

    localparam int SERIES_TERMS = 6;
    localparam int TRIG_LAT     = 4 + 3 * SERIES_TERMS + 2;

    localparam logic [7:0] DIV_COS [SERIES_TERMS] =
        '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
    localparam logic [7:0] DIV_SIN [SERIES_TERMS] =
        '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};

    // floor(2^32 / divisor)
    localparam logic [31:0] RCP_COS [SERIES_TERMS] = '{
        32'(64'h1_0000_0000 / 64'd132), 32'(64'h1_0000_0000 / 64'd90),
        32'(64'h1_0000_0000 / 64'd56),  32'(64'h1_0000_0000 / 64'd30),
        32'(64'h1_0000_0000 / 64'd12),  32'(64'h1_0000_0000 / 64'd2)};
    localparam logic [31:0] RCP_SIN [SERIES_TERMS] = '{
        32'(64'h1_0000_0000 / 64'd156), 32'(64'h1_0000_0000 / 64'd110),
        32'(64'h1_0000_0000 / 64'd72),  32'(64'h1_0000_0000 / 64'd42),
        32'(64'h1_0000_0000 / 64'd20),  32'(64'h1_0000_0000 / 64'd6)};

    // window coefficients, Q30
    localparam logic [29:0] HANN_A     = 30'd536870912;
    localparam logic [29:0] HAMMING_A0 = 30'd583555339;
    localparam logic [29:0] HAMMING_A1 = 30'd490186485;
    localparam logic [29:0] FLAT_A0    = 30'd231476135;
    localparam logic [29:0] FLAT_A1    = 30'd447354753;
    localparam logic [29:0] FLAT_A2    = 30'd297709049;
    localparam logic [29:0] FLAT_A3    = 30'd89742211;
    localparam logic [29:0] FLAT_A4    = 30'd7459680;

endpackage

`default_nettype wire

[rtl/wcg_phase.sv]
`default_nettype none

// Pipelined long division: {index, 32'b0} / divisor, low 32 quotient bits
module wcg_phase (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [wcg_pkg::INDEX_W-1:0] i_index,
    input  logic [wcg_pkg::INDEX_W-1:0] i_divisor,
    output logic                        o_valid,
    output logic [wcg_pkg::PHASE_W-1:0] o_phase
);

    localparam int NSTG = wcg_pkg::DIV_STAGES;
    localparam int NB   = wcg_pkg::DIV_BITS;
    localparam int IW   = wcg_pkg::INDEX_W;

    logic [IW-1:0] r_rem [NSTG];
    logic [NB-1:0] r_num [NSTG];
    logic          r_v   [NSTG];

    for (genvar gs = 0; gs < NSTG; gs++) begin : g_stage
        logic [IW-1:0] rem_in;
        logic [NB-1:0] num_in;
        logic          v_in;
        logic [IW-1:0] n_rem;
        logic [NB-1:0] n_num;
        logic [IW:0]   sh;

        if (gs == 0) begin : g_first
            assign rem_in = '0;
            assign num_in = {i_index, {wcg_pkg::PHASE_W{1'b0}}};
            assign v_in   = i_valid;
        end else begin : g_next
            assign rem_in = r_rem[gs-1];
            assign num_in = r_num[gs-1];
            assign v_in   = r_v[gs-1];
        end

        always_comb begin
            n_rem = rem_in;
            n_num = num_in;
            sh    = '0;
            for (int j = 0; j < wcg_pkg::DIV_STEP; j++) begin
                sh    = {n_rem, n_num[NB-1]};
                n_num = {n_num[NB-2:0], 1'b0};
                if (sh >= {1'b0, i_divisor}) begin
                    n_rem    = IW'(sh - {1'b0, i_divisor});
                    n_num[0] = 1'b1;
                end else begin
                    n_rem = sh[IW-1:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[gs] <= 1'b0;
            end else begin
                r_v[gs] <= v_in;
            end
            r_rem[gs] <= n_rem;
            r_num[gs] <= n_num;
        end
    end

    assign o_valid = r_v[NSTG-1];
    assign o_phase = r_num[NSTG-1][wcg_pkg::PHASE_W-1:0];

endmodule

`default_nettype wire

[rtl/wcg_trig.sv]
`default_nettype none

// Pipelined cosine of a turn fraction, Q30 signed. Octant fold, then one
// Horner series (cos or sin terms per word), then quadrant sign.
module wcg_trig (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [wcg_pkg::PHASE_W-1:0] i_phase,
    output logic                        o_valid,
    output logic signed [31:0]          o_cos
);

    localparam int NI = wcg_pkg::SERIES_TERMS;
    localparam int NS = 3 * NI;

    // fold
    logic [29:0] fold_r;
    logic        fold_sel;
    logic        fold_neg;

    always_comb begin
        if (!i_phase[29]) begin
            fold_r = i_phase[29:0];
        end else begin
            fold_r = 30'(31'h4000_0000 - {1'b0, i_phase[29:0]});
        end
        // sin terms when odd quadrant xor upper half of quadrant
        fold_sel = i_phase[30] ^ i_phase[29];
        fold_neg = i_phase[31] ^ i_phase[30];
    end

    logic [29:0] r_r0;
    logic        r_sel0, r_neg0, r_v0;
    logic [60:0] r_plo;
    logic [32:0] r_phi;
    logic        r_sel1, r_neg1, r_v1;
    logic [29:0] r_x;
    logic        r_sel2, r_neg2, r_v2;

    logic [64:0] ang_sum;
    logic [59:0] sq;

    // delay line slots
    logic [29:0] r_xd   [NS+1];
    logic [29:0] r_x2d  [NS+1];
    logic        r_seld [NS+1];
    logic        r_negd [NS+1];
    logic        r_vd   [NS+1];

    always_comb begin
        ang_sum = {r_phi, 32'b0} + {4'b0, r_plo};
        sq      = r_x * r_x;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
        r_r0   <= fold_r;
        r_sel0 <= fold_sel;
        r_neg0 <= fold_neg;
        r_plo  <= r_r0 * wcg_pkg::C_LO;
        r_phi  <= r_r0 * wcg_pkg::C_HI;
        r_sel1 <= r_sel0;
        r_neg1 <= r_neg0;
        r_x    <= ang_sum[63:34];
        r_sel2 <= r_sel1;
        r_neg2 <= r_neg1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= NS; s++) begin
                r_vd[s] <= 1'b0;
            end
        end else begin
            r_vd[0] <= r_v2;
            for (int s = 1; s <= NS; s++) begin
                r_vd[s] <= r_vd[s-1];
            end
        end
        r_xd[0]   <= r_x;
        r_x2d[0]  <= sq[59:30];
        r_seld[0] <= r_sel2;
        r_negd[0] <= r_neg2;
        for (int s = 1; s <= NS; s++) begin
            r_xd[s]   <= r_xd[s-1];
            r_x2d[s]  <= r_x2d[s-1];
            r_seld[s] <= r_seld[s-1];
            r_negd[s] <= r_negd[s-1];
        end
    end

    // Horner terms: t = 1 - (x2 * t) / div, three stages each
    logic [60:0] r_p [NI];
    logic [29:0] r_a [NI];
    logic [61:0] r_m [NI];
    logic [30:0] r_t [NI];

    for (genvar gi = 0; gi < NI; gi++) begin : g_term
        logic [30:0] t_in;
        logic [31:0] rcp;
        logic [7:0]  dv;
        logic [29:0] q0;
        logic [29:0] rem;
        logic [29:0] q;

        if (gi == 0) begin : g_first
            assign t_in = wcg_pkg::ONE_Q30;
        end else begin : g_next
            assign t_in = r_t[gi-1];
        end

        always_comb begin
            rcp = r_seld[3*gi+1] ? wcg_pkg::RCP_SIN[gi] : wcg_pkg::RCP_COS[gi];
            dv  = r_seld[3*gi+2] ? wcg_pkg::DIV_SIN[gi] : wcg_pkg::DIV_COS[gi];
            q0  = r_m[gi][61:32];
            // estimate is low by at most one
            rem = r_a[gi] - q0 * dv;
            q   = (rem >= 30'(dv)) ? 30'(q0 + 30'd1) : q0;
        end

        always_ff @(posedge i_clk) begin
            r_p[gi] <= r_x2d[3*gi] * t_in;
            r_a[gi] <= r_p[gi][59:30];
            r_m[gi] <= r_p[gi][59:30] * rcp;
            r_t[gi] <= wcg_pkg::ONE_Q30 - {1'b0, q};
        end
    end

    logic [60:0] r_fm;
    logic        r_fneg, r_fv;
    logic [31:0] mag;

    assign mag = {1'b0, r_fm[60:30]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_fv    <= r_vd[NS];
            o_valid <= r_fv;
        end
        if (r_seld[NS]) begin
            r_fm <= r_xd[NS] * r_t[NI-1];
        end else begin
            r_fm <= {r_t[NI-1], 30'b0};
        end
        r_fneg <= r_negd[NS];
        o_cos  <= r_fneg ? -$signed(mag) : $signed(mag);
    end

endmodule

`default_nettype wire

[rtl/window_coefficient_generator.sv]
// Channel   Handshake                     Payload
// ------    ---------------------------   ------------------------------
// input     i_start, o_busy               i_sample_index [12:0]
// result    o_valid (one-cycle strobe)    o_coefficient  [15:0] signed
// config    i_cfg_valid, o_cfg_ready      i_cfg_index [1:0], i_cfg_data [13:0]
//
// One word accepted per cycle while o_busy is low; each result passes
// through 15 stages of phase division, 18 stages of cosine series
// (six Horner terms at three stages each) and 12 stages of input register,
// harmonics, fold, window sum and rounding. Synchronous reset clears the
// valid bits and holds o_busy high; it falls in the cycle after release. The
// receiver cannot stall, so the pipeline never holds.
`default_nettype none

module window_coefficient_generator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [wcg_pkg::INDEX_W-1:0]   i_sample_index,
    output logic                          o_valid,
    output logic signed [wcg_pkg::COEF_W-1:0] o_coefficient,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [wcg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [wcg_pkg::LEN_W-1:0]     i_cfg_data
);

    localparam int LATENCY = 1 + wcg_pkg::DIV_STAGES + 1 + wcg_pkg::TRIG_LAT + 4;
    localparam logic signed [31:0] COS_MAX = 32'sd1073741824;

    logic                      r_busy;
    logic [wcg_pkg::LEN_W-1:0] r_len;
    wcg_pkg::t_kind            r_kind;
    logic                      accept;

    assign o_busy      = r_busy;
    assign o_cfg_ready = ~r_busy;
    assign accept      = i_start && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_len  <= wcg_pkg::MAX_POINTS;
            r_kind <= wcg_pkg::KIND_RECT;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == wcg_pkg::CFG_LENGTH) begin
                    r_len <= i_cfg_data;
                end else if (i_cfg_index == wcg_pkg::CFG_KIND) begin
                    r_kind <= wcg_pkg::t_kind'(i_cfg_data[1:0]);
                end
            end
        end
    end

    logic [wcg_pkg::LEN_W-1:0]   len_sat;
    logic [wcg_pkg::INDEX_W-1:0] divisor;
    logic                        short_win;

    always_comb begin
        len_sat   = (r_len > wcg_pkg::MAX_POINTS) ? wcg_pkg::MAX_POINTS : r_len;
        divisor   = wcg_pkg::INDEX_W'(len_sat - 14'd1);
        short_win = r_len < 14'd2;
    end

    logic                        r_v_in;
    logic [wcg_pkg::INDEX_W-1:0] r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_in <= 1'b0;
        end else begin
            r_v_in <= accept;
        end
        r_idx <= i_sample_index;
    end

    logic                        w_ph_v;
    logic [wcg_pkg::PHASE_W-1:0] w_ph;

    wcg_phase u_phase (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_v_in),
        .i_index   (r_idx),
        .i_divisor (divisor),
        .o_valid   (w_ph_v),
        .o_phase   (w_ph)
    );

    // harmonic phases, modulo one turn
    logic [wcg_pkg::PHASE_W-1:0] ph;
    logic [wcg_pkg::PHASE_W-1:0] r_h [4];
    logic                        r_h_v;

    assign ph = short_win ? '0 : w_ph;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_v <= 1'b0;
        end else begin
            r_h_v <= w_ph_v;
        end
        r_h[0] <= ph;
        r_h[1] <= {ph[30:0], 1'b0};
        r_h[2] <= ph + {ph[30:0], 1'b0};
        r_h[3] <= {ph[29:0], 2'b0};
    end

    logic               w_cos_v [4];
    logic signed [31:0] w_cos   [4];

    for (genvar gh = 0; gh < 4; gh++) begin : g_harm
        wcg_trig u_trig (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (r_h_v),
            .i_phase (r_h[gh]),
            .o_valid (w_cos_v[gh]),
            .o_cos   (w_cos[gh])
        );
    end

    // term products
    logic [29:0]        coef [4];
    logic signed [62:0] r_tm [4];
    logic               r_v2;

    always_comb begin
        unique case (r_kind)
            wcg_pkg::KIND_HANN:    coef[0] = wcg_pkg::HANN_A;
            wcg_pkg::KIND_HAMMING: coef[0] = wcg_pkg::HAMMING_A1;
            default:               coef[0] = wcg_pkg::FLAT_A1;
        endcase
        coef[1] = wcg_pkg::FLAT_A2;
        coef[2] = wcg_pkg::FLAT_A3;
        coef[3] = wcg_pkg::FLAT_A4;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= w_cos_v[0];
        end
        for (int j = 0; j < 4; j++) begin
            r_tm[j] <= $signed({1'b0, coef[j]}) * w_cos[j];
        end
    end

    // window sum
    logic signed [33:0] term [4];
    logic signed [33:0] n_v;
    logic signed [33:0] r_v;
    logic               r_v3;

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            term[j] = 34'($signed(r_tm[j][62:30]));
        end
        unique case (r_kind)
            wcg_pkg::KIND_RECT:    n_v = $signed({3'b0, wcg_pkg::ONE_Q30});
            wcg_pkg::KIND_HANN:    n_v = $signed({4'b0, wcg_pkg::HANN_A}) - term[0];
            wcg_pkg::KIND_HAMMING: n_v = $signed({4'b0, wcg_pkg::HAMMING_A0}) - term[0];
            wcg_pkg::KIND_FLAT:    n_v = $signed({4'b0, wcg_pkg::FLAT_A0}) - term[0]
                                         + term[1] - term[2] + term[3];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_v <= n_v;
    end

    // half-up offset, then truncate toward zero and saturate
    logic signed [33:0] r_sum;
    logic               r_v4;
    logic signed [33:0] rnd;
    logic signed [18:0] q15;
    logic signed [wcg_pkg::COEF_W-1:0] n_coef;

    always_comb begin
        rnd = r_sum[33] ? (r_sum + 34'sd32767) : r_sum;
        q15 = rnd[33:15];
        if (q15 > 19'sd32767) begin
            n_coef = 16'sh7FFF;
        end else if (q15 < -19'sd32768) begin
            n_coef = 16'sh8000;
        end else begin
            n_coef = q15[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v4    <= r_v3;
            o_valid <= r_v4;
        end
        r_sum         <= r_v + 34'sd16384;
        o_coefficient <= n_coef;
    end

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, LATENCY))
        else $error("result strobe without a matching accepted word");

    a_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cos_v[0] == w_cos_v[1] && w_cos_v[0] == w_cos_v[2] &&
        w_cos_v[0] == w_cos_v[3])
        else $error("harmonic lanes out of step");

    a_cos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cos_v[0] |-> (w_cos[0] <= COS_MAX && w_cos[0] >= -COS_MAX))
        else $error("cosine out of range");

    a_harm_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ph_v |=> r_h_v)
        else $error("phase word lost before harmonic stage");

endmodule

`default_nettype wire

[tb/sv/window_coefficient_generator_test.sv]
`timescale 1ns / 1ps

module window_coefficient_generator_test;

    localparam int PIPE_WAIT  = 60;
    localparam int STALL_MAX  = 20000;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_start = 1'b0;
    logic                              o_busy;
    logic [wcg_pkg::INDEX_W-1:0]       i_sample_index = '0;
    logic                              o_valid;
    logic signed [wcg_pkg::COEF_W-1:0] o_coefficient;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [wcg_pkg::CFG_IDX_W-1:0]     i_cfg_index = wcg_pkg::CFG_LENGTH;
    logic [wcg_pkg::LEN_W-1:0]         i_cfg_data = '0;

    window_coefficient_generator uut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // shadow of the block's registers
    logic [wcg_pkg::LEN_W-1:0] win_len;
    wcg_pkg::t_kind            win_kind;

    logic signed [wcg_pkg::COEF_W-1:0] coef_pending[$];
    int errors;
    int words_sent;
    int coefs_seen;
    int cfg_writes;
    int stall_cycles;
    int sender_idle_pct;

    typedef struct {
        wcg_pkg::t_kind                    kind;
        logic [wcg_pkg::LEN_W-1:0]         len;
        logic [wcg_pkg::INDEX_W-1:0]       idx;
        bit                                known;
        logic signed [wcg_pkg::COEF_W-1:0] coef;
    } t_row;

    // rows with known set carry the value computed by hand
    t_row rows[] = '{
        '{wcg_pkg::KIND_RECT,    14'd8192,  13'd0,    1'b1, 16'sd32767},
        '{wcg_pkg::KIND_RECT,    14'd8192,  13'd8191, 1'b1, 16'sd32767},
        '{wcg_pkg::KIND_HANN,    14'd8192,  13'd0,    1'b1, 16'sd0},
        '{wcg_pkg::KIND_HANN,    14'd8192,  13'd4095, 1'b0, 16'sd0},
        '{wcg_pkg::KIND_HANN,    14'd8192,  13'd8191, 1'b0, 16'sd0},
        '{wcg_pkg::KIND_HANN,    14'd5,     13'd2,    1'b1, 16'sd32767},
        '{wcg_pkg::KIND_HANN,    14'd5,     13'd6,    1'b1, 16'sd32767},
        '{wcg_pkg::KIND_HANN,    14'd5,     13'd8191, 1'b0, 16'sd0},
        '{wcg_pkg::KIND_HANN,    14'd1,     13'd1234, 1'b1, 16'sd0},
        '{wcg_pkg::KIND_HANN,    14'd0,     13'd8191, 1'b1, 16'sd0},
        '{wcg_pkg::KIND_HAMMING, 14'd0,     13'd77,   1'b1, 16'sd2849},
        '{wcg_pkg::KIND_HAMMING, 14'd2,     13'd1,    1'b1, 16'sd2849},
        '{wcg_pkg::KIND_HAMMING, 14'd16383, 13'd4000, 1'b0, 16'sd0},
        '{wcg_pkg::KIND_HAMMING, 14'd16383, 13'd8191, 1'b1, 16'sd2849},
        '{wcg_pkg::KIND_HAMMING, 14'd8193,  13'd100,  1'b0, 16'sd0},
        '{wcg_pkg::KIND_FLAT,    14'd8193,  13'd0,    1'b1, -16'sd13},
        '{wcg_pkg::KIND_FLAT,    14'd64,    13'd31,   1'b0, 16'sd0},
        '{wcg_pkg::KIND_FLAT,    14'd64,    13'd17,   1'b0, 16'sd0},
        '{wcg_pkg::KIND_FLAT,    14'd3,     13'd1,    1'b0, 16'sd0},
        '{wcg_pkg::KIND_FLAT,    14'd9,     13'd5,    1'b0, 16'sd0},
        '{wcg_pkg::KIND_RECT,    14'd2,     13'd5,    1'b1, 16'sd32767}
    };

    function automatic logic [63:0] turn_to_rad(input logic [63:0] r);
        logic [63:0] p;
        p = r * 64'd26986075409;
        return p >> 34;
    endfunction

    function automatic logic [63:0] horner(input logic [63:0] x, input bit sine_terms);
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] dv;
        x2 = (x * x) >> 30;
        t = 64'(wcg_pkg::ONE_Q30);
        for (int i = 0; i < wcg_pkg::SERIES_TERMS; i++) begin
            dv = sine_terms ? 64'(wcg_pkg::DIV_SIN[i]) : 64'(wcg_pkg::DIV_COS[i]);
            t = 64'(wcg_pkg::ONE_Q30) - ((x2 * t) >> 30) / dv;
        end
        return sine_terms ? (x * t) >> 30 : t;
    endfunction

    function automatic longint cos_of_turn(input logic [31:0] p);
        logic [63:0] f;
        logic [63:0] x;
        longint c;
        longint s;
        f = {34'd0, p[29:0]};
        if (f < 64'd536870912) begin
            x = turn_to_rad(f);
            c = longint'(horner(x, 1'b0));
            s = longint'(horner(x, 1'b1));
        end else begin
            x = turn_to_rad(64'd1073741824 - f);
            c = longint'(horner(x, 1'b1));
            s = longint'(horner(x, 1'b0));
        end
        case (p[31:30])
            2'd0: return c;
            2'd1: return -s;
            2'd2: return -c;
            default: return s;
        endcase
    endfunction

    function automatic logic signed [wcg_pkg::COEF_W-1:0] window_coef(
        input logic [wcg_pkg::INDEX_W-1:0] idx);
        logic [63:0] n;
        logic [63:0] d;
        logic [31:0] ph;
        longint v;
        longint sum;
        longint q;
        n = 64'(win_len);
        ph = '0;
        if (n > 64'd8192) n = 64'd8192;
        if (n >= 2) begin
            d = n - 1;
            ph = 32'(((64'(idx) % d) << 32) / d);
        end
        case (win_kind)
            wcg_pkg::KIND_RECT: v = 64'sd1073741824;
            wcg_pkg::KIND_HANN:
                v = longint'(wcg_pkg::HANN_A)
                    - ((longint'(wcg_pkg::HANN_A) * cos_of_turn(ph)) >>> 30);
            wcg_pkg::KIND_HAMMING:
                v = longint'(wcg_pkg::HAMMING_A0)
                    - ((longint'(wcg_pkg::HAMMING_A1) * cos_of_turn(ph)) >>> 30);
            default:
                v = longint'(wcg_pkg::FLAT_A0)
                    - ((longint'(wcg_pkg::FLAT_A1) * cos_of_turn(ph)) >>> 30)
                    + ((longint'(wcg_pkg::FLAT_A2) * cos_of_turn(32'(ph * 2))) >>> 30)
                    - ((longint'(wcg_pkg::FLAT_A3) * cos_of_turn(32'(ph * 3))) >>> 30)
                    + ((longint'(wcg_pkg::FLAT_A4) * cos_of_turn(32'(ph * 4))) >>> 30);
        endcase
        sum = v + 64'sd16384;
        q = (sum >= 0) ? (sum >>> 15) : -((-sum) >>> 15);
        if (q > 32767) q = 32767;
        else if (q < -32768) q = -32768;
        return wcg_pkg::COEF_W'(q);
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        $display("mismatch %s: got %0d, expected %0d", what, got, want);
    endtask

    // result checker and watchdog
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid || (i_cfg_valid && o_cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_MAX) begin
            $display("watchdog: no handshake for %0d cycles", STALL_MAX);
            $display("window_coefficient_generator test failed");
            $finish;
        end
        if (i_rst_n && o_valid) begin
            coefs_seen++;
            if (coef_pending.size() == 0)
                report_mismatch("unexpected coefficient", o_coefficient, 0);
            else if (o_coefficient !== coef_pending[0]) begin
                report_mismatch("coefficient", o_coefficient, coef_pending[0]);
                void'(coef_pending.pop_front());
            end else
                void'(coef_pending.pop_front());
        end
    end

    task automatic drain;
        while (coef_pending.size() != 0) @(posedge i_clk);
        repeat (PIPE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [wcg_pkg::CFG_IDX_W-1:0] ri,
                             input logic [wcg_pkg::LEN_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= ri;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (ri == wcg_pkg::CFG_LENGTH) win_len = val;
        else win_kind = wcg_pkg::t_kind'(val[1:0]);
        cfg_writes++;
    endtask

    task automatic set_window(input wcg_pkg::t_kind kind,
                              input logic [wcg_pkg::LEN_W-1:0] len);
        if (kind == win_kind && len == win_len) return;
        i_start <= 1'b0;
        drain();
        write_reg(wcg_pkg::CFG_LENGTH, len);
        write_reg(wcg_pkg::CFG_KIND, wcg_pkg::LEN_W'(kind));
    endtask

    // i_start stays high across back-to-back words
    task automatic send_word(input logic [wcg_pkg::INDEX_W-1:0] idx, input bit known,
                             input logic signed [wcg_pkg::COEF_W-1:0] coef);
        if ($urandom_range(99) < sender_idle_pct) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_sample_index <= idx;
        do @(posedge i_clk); while (o_busy);
        coef_pending.push_back(known ? coef : window_coef(idx));
        words_sent++;
    endtask

    function automatic logic [wcg_pkg::LEN_W-1:0] pick_length(input int sel);
        case (sel)
            0: return 14'd2;
            1: return 14'd8192;
            2: return 14'd16383;
            3: return wcg_pkg::LEN_W'($urandom_range(2, 40));
            4: return wcg_pkg::LEN_W'($urandom_range(0, 16383));
            default: return wcg_pkg::LEN_W'($urandom_range(2, 8192));
        endcase
    endfunction

    initial begin
        logic [wcg_pkg::INDEX_W-1:0] idx;
        int idle_pcts[4] = '{0, 69, 0, 36};
        errors = 0;
        words_sent = 0;
        coefs_seen = 0;
        cfg_writes = 0;
        stall_cycles = 0;
        sender_idle_pct = 0;
        win_len = 14'd8192;
        win_kind = wcg_pkg::KIND_RECT;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) begin
            set_window(rows[i].kind, rows[i].len);
            send_word(rows[i].idx, rows[i].known, rows[i].coef);
        end
        i_start <= 1'b0;

        for (int blk = 0; blk < 8; blk++) begin
            sender_idle_pct = idle_pcts[blk % 4];
            drain();
            write_reg(wcg_pkg::CFG_LENGTH, pick_length(blk < 3 ? blk : $urandom_range(3, 6)));
            write_reg(wcg_pkg::CFG_KIND, wcg_pkg::LEN_W'($urandom_range(0, 3)));
            for (int n = 0; n < 160; n++) begin
                if (n == 80 && blk == 2) begin
                    // let the pipeline run dry once
                    i_start <= 1'b0;
                    while (coef_pending.size() != 0) @(posedge i_clk);
                end
                if ($urandom_range(3) == 0 && win_len >= 2 && win_len <= 8192)
                    idx = wcg_pkg::INDEX_W'($urandom_range(0, win_len - 1));
                else
                    idx = wcg_pkg::INDEX_W'($urandom_range(0, 8191));
                send_word(idx, 1'b0, '0);
            end
            i_start <= 1'b0;
        end

        while (coef_pending.size() != 0) @(posedge i_clk);
        repeat (PIPE_WAIT) @(posedge i_clk);
        $display("covered %0d words, %0d coefficients, %0d register writes", words_sent,
                 coefs_seen, cfg_writes);
        $display("all four window kinds, lengths 0 to 16383, full index range, idle mixes");
        if (errors == 0)
            $display("window_coefficient_generator test passed");
        else
            $display("window_coefficient_generator test failed");
        $finish;
    end

endmodule
